@@ design/eafp_pkg.sv @@
package eafp_pkg;

  localparam int COORD_W           = 20;
  localparam int DIFF_W            = COORD_W + 1;
  localparam int ANGLE_W           = 16;
  localparam int BETA_W            = 15;
  localparam int THR_W             = 43;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_TAB_LEN      = 24;
  localparam int NORM_W            = 40;
  localparam int CORDIC_W          = 44;
  localparam int ZACC_W            = 32;
  localparam int ROOT_W            = 64;
  localparam int SQRT_CELLS        = 32;
  localparam int NORM_R_STAGES     = 7;
  localparam int NORM_L_STAGES     = 6;

  localparam logic signed [ZACC_W-1:0] HALF_PI_Q24 = 32'sd26353589;
  localparam logic signed [ANGLE_W-1:0] PI_Q13     = 16'sd25736;

  localparam logic [ZACC_W-1:0] ATAN_Q24 [0:ATAN_TAB_LEN-1] = '{
    32'd13176795, 32'd7778716, 32'd4110060, 32'd2086331, 32'd1047214, 32'd524117,
    32'd262123, 32'd131069, 32'd65536, 32'd32768, 32'd16384, 32'd8192,
    32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128,
    32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

endpackage

@@ design/eafp_delay.sv @@
module eafp_delay import eafp_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         adv,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] tap_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      tap_r[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign d_o = tap_r[DEPTH-1];

endmodule

@@ design/eafp_sqrt_cell.sv @@
module eafp_sqrt_cell import eafp_pkg::*; #(
  parameter int BIT_POS = 62
) (
  input  logic              clk,
  input  logic              adv,
  input  logic [ROOT_W-1:0] rem_i,
  input  logic [ROOT_W-1:0] root_i,
  output logic [ROOT_W-1:0] rem_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam logic [ROOT_W-1:0] ONE_BIT = ROOT_W'(1) << BIT_POS;

  logic [ROOT_W-1:0] trial;

  assign trial = root_i + ONE_BIT;

  // restore-free step: take the bit when the trial fits
  always_ff @(posedge clk) begin
    if (adv) begin
      if (rem_i >= trial) begin
        rem_o  <= rem_i - trial;
        root_o <= (root_i >> 1) + ONE_BIT;
      end else begin
        rem_o  <= rem_i;
        root_o <= root_i >> 1;
      end
    end
  end

endmodule

@@ design/eafp_norm_cell.sv @@
module eafp_norm_cell import eafp_pkg::*; #(
  parameter int W     = NORM_W,
  parameter int K     = 1,
  parameter bit RIGHT = 1'b1
) (
  input  logic         clk,
  input  logic         adv,
  input  logic [W-1:0] ym_i,
  input  logic [W-1:0] xm_i,
  output logic [W-1:0] ym_o,
  output logic [W-1:0] xm_o
);

  logic [W-1:0] orv;
  logic         hit;

  assign orv = ym_i | xm_i;

  generate
    if (RIGHT) begin : g_right
      if (NORM_W - 1 + K < W) begin : g_chk
        assign hit = |orv[W-1:NORM_W-1+K];
      end else begin : g_none
        assign hit = 1'b0;
      end
    end else begin : g_left
      assign hit = ~|orv[NORM_W-1:NORM_W-1-K];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!hit) begin
        ym_o <= ym_i;
        xm_o <= xm_i;
      end else if (RIGHT) begin
        ym_o <= ym_i >> K;
        xm_o <= xm_i >> K;
      end else begin
        ym_o <= ym_i << K;
        xm_o <= xm_i << K;
      end
    end
  end

endmodule

@@ design/eafp_cordic_cell.sv @@
module eafp_cordic_cell import eafp_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  logic                       adv,
  input  logic signed [CORDIC_W-1:0] x_i,
  input  logic signed [CORDIC_W-1:0] y_i,
  input  logic signed [ZACC_W-1:0]   z_i,
  output logic signed [CORDIC_W-1:0] x_o,
  output logic signed [CORDIC_W-1:0] y_o,
  output logic signed [ZACC_W-1:0]   z_o
);

  localparam logic signed [ZACC_W-1:0] ANG = ATAN_Q24[IDX];

  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;

  assign dx = y_i >>> IDX;
  assign dy = x_i >>> IDX;

  // rotate towards y = 0
  always_ff @(posedge clk) begin
    if (adv) begin
      if (y_i >= 0) begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + ANG;
      end else begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - ANG;
      end
    end
  end

endmodule

@@ design/eafp_atan_pipe.sv @@
module eafp_atan_pipe import eafp_pkg::*; #(
  parameter int IN_W   = 42,
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic                      yneg,
  input  logic                      xneg,
  input  logic [IN_W-1:0]           ym,
  input  logic [IN_W-1:0]           xm,
  output logic signed [ANGLE_W-1:0] angle_r
);

  localparam int RW = (IN_W > NORM_W) ? IN_W : NORM_W;
  localparam int QW = ZACC_W - 11;

  logic [RW-1:0]     ry [0:NORM_R_STAGES];
  logic [RW-1:0]     rx [0:NORM_R_STAGES];
  logic [NORM_W-1:0] ly [0:NORM_L_STAGES];
  logic [NORM_W-1:0] lx [0:NORM_L_STAGES];

  logic signed [CORDIC_W-1:0] cx [0:STAGES];
  logic signed [CORDIC_W-1:0] cy [0:STAGES];
  logic signed [ZACC_W-1:0]   cz [0:STAGES];

  logic [2:0] flg_in, flg_d;
  logic       zero_d;

  logic signed [CORDIC_W-1:0] ys, xs;
  logic signed [ZACC_W-1:0]   zr;
  logic signed [QW-1:0]       q;

  assign ry[0]  = RW'(ym);
  assign rx[0]  = RW'(xm);
  assign flg_in = {~|(ym | xm), yneg, xneg};

  // right normalise: bring the leading one down to bit 39
  for (genvar r = 0; r < NORM_R_STAGES; r++) begin : g_rn
    eafp_norm_cell #(.W(RW), .K(64 >> r), .RIGHT(1'b1)) u_cell (
      .clk(clk), .adv(adv), .ym_i(ry[r]), .xm_i(rx[r]), .ym_o(ry[r+1]), .xm_o(rx[r+1])
    );
  end

  assign ly[0] = ry[NORM_R_STAGES][NORM_W-1:0];
  assign lx[0] = rx[NORM_R_STAGES][NORM_W-1:0];

  // left normalise: lift the leading one to bit 38 at least
  for (genvar l = 0; l < NORM_L_STAGES; l++) begin : g_ln
    eafp_norm_cell #(.W(NORM_W), .K(32 >> l), .RIGHT(1'b0)) u_cell (
      .clk(clk), .adv(adv), .ym_i(ly[l]), .xm_i(lx[l]), .ym_o(ly[l+1]), .xm_o(lx[l+1])
    );
  end

  eafp_delay #(.W(3), .DEPTH(NORM_R_STAGES + NORM_L_STAGES)) u_flg (
    .clk(clk), .adv(adv), .d_i(flg_in), .d_o(flg_d)
  );

  eafp_delay #(.W(1), .DEPTH(STAGES + 1)) u_zero (
    .clk(clk), .adv(adv), .d_i(flg_d[2]), .d_o(zero_d)
  );

  assign ys = flg_d[1] ? -CORDIC_W'(ly[NORM_L_STAGES]) : CORDIC_W'(ly[NORM_L_STAGES]);
  assign xs = flg_d[0] ? -CORDIC_W'(lx[NORM_L_STAGES]) : CORDIC_W'(lx[NORM_L_STAGES]);

  // quarter turn for the left half plane
  always_ff @(posedge clk) begin
    if (adv) begin
      if (xs >= 0) begin
        cx[0] <= xs;
        cy[0] <= ys;
        cz[0] <= '0;
      end else if (ys >= 0) begin
        cx[0] <= ys;
        cy[0] <= -xs;
        cz[0] <= HALF_PI_Q24;
      end else begin
        cx[0] <= -ys;
        cy[0] <= xs;
        cz[0] <= -HALF_PI_Q24;
      end
    end
  end

  for (genvar c = 0; c < STAGES; c++) begin : g_cd
    eafp_cordic_cell #(.IDX(c)) u_cell (
      .clk(clk), .adv(adv),
      .x_i(cx[c]), .y_i(cy[c]), .z_i(cz[c]),
      .x_o(cx[c+1]), .y_o(cy[c+1]), .z_o(cz[c+1])
    );
  end

  assign zr = cz[STAGES] + 32'sd1024;
  assign q  = zr[ZACC_W-1:11];

  // round half up to Q3.13 and clamp to +-pi
  always_ff @(posedge clk) begin
    if (adv) begin
      if (zero_d) begin
        angle_r <= '0;
      end else if (q > QW'(PI_Q13)) begin
        angle_r <= PI_Q13;
      end else if (q < -QW'(PI_Q13)) begin
        angle_r <= -PI_Q13;
      end else begin
        angle_r <= ANGLE_W'(q);
      end
    end
  end

endmodule

@@ design/euler_angles_from_three_points.sv @@
// Z-Y-Z Euler angles of the local frame spanned by three points. Each input
// transaction carries a centre, an upper and a lateral point in signed Q10.10;
// the block forms z = upper - centre, x = (lateral - centre) x z, y = z x x
// and returns alpha and gamma in Q3.13, beta in unsigned Q2.13 (radians) with a flag
// for the degenerate case, where the squared xy projection of z is at or
// below axis_threshold (cfg port, reset 0). The datapath is one fixed chain
// of cells: three exact multiply stages, a 32-cell bit-per-cycle square-root
// chain and three CORDIC chains of 13 normalise cells, one quarter-turn cell
// and CORDIC_STAGES rotation cells each. One transaction is accepted every
// cycle while the output is not stalled. A stalled output holds the whole
// chain in place.
module euler_angles_from_three_points import eafp_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata, lowest bit up: center_x, center_y, center_z, upper_x, upper_y,
  // upper_z, lateral_x, lateral_y, lateral_z (20 bits each), 4 bits zero
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [183:0] in_tdata,
  // out_tdata, lowest bit up: alpha_angle (16), beta_angle (15),
  // gamma_angle (16), 1 bit zero
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,
  // out_tuser: degenerate
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  localparam int ATAN_LAT = NORM_R_STAGES + NORM_L_STAGES + 2 + CORDIC_STAGES;
  localparam int LAT      = 3 + (SQRT_CELLS - 1) + ATAN_LAT + 1;
  localparam int A_DLY    = SQRT_CELLS - 3;
  localparam int G_DLY    = SQRT_CELLS - 1;
  localparam int F_DLY    = SQRT_CELLS - 1 + ATAN_LAT;
  localparam int YA_W     = 85;
  localparam int BM_W     = 63;
  localparam int GM_W     = 42;
  localparam int BT_W     = 31;

  logic               adv;
  logic [LAT-1:0]     vld_r, vld_nxt;
  logic [THR_W-1:0]   thr_r;

  // stage 1: difference vectors
  logic signed [DIFF_W-1:0] z0_r, z1_r, z2_r, s0_r, s1_r, s2_r;
  // stage 2: cross product and squares
  logic signed [42:0] x0_r, x1_r, x2_r;
  logic [41:0]        p_r;
  logic [40:0]        z2sq_r;
  logic signed [DIFF_W-1:0] z0b_r, z1b_r, z2b_r;
  // stage 3
  logic [42:0]        nz_r;
  logic [41:0]        mx2_r;
  logic               x2neg_r, bneg_r, degen_r, z2pos_r, z2neg_r;
  logic [BM_W-1:0]    mb_r;
  logic [DIFF_W-1:0]  z2m_r;
  logic               gyneg_r, gxneg_r;
  logic [GM_W-1:0]    gym_r, gxm_r;
  logic signed [63:0] b_nxt;
  logic signed [42:0] gy_nxt, gx_nxt;
  logic               degen_nxt;
  // stage 4 and 5: wide product of |x2| and |z|^2
  logic [63:0]        pp_lo_r;
  logic [62:0]        pp_hi_r;
  logic               x2neg4_r, bneg4_r, x2neg5_r, bneg5_r;
  logic [BM_W-1:0]    mb4_r, mb5_r;
  logic [YA_W-1:0]    ya_r;

  logic [ROOT_W-1:0]  sq_rem [0:SQRT_CELLS];
  logic [ROOT_W-1:0]  sq_root [0:SQRT_CELLS];

  logic [YA_W+BM_W+1:0]   a_d;
  logic [2*GM_W+1:0]      g_d;
  logic [DIFF_W:0]        bx_d;
  logic [1:0]             f_d;
  logic signed [ANGLE_W-1:0] a_ang, b_ang, g_ang;

  logic [ANGLE_W-1:0] alpha_r, gamma_r;
  logic [BETA_W-1:0]  beta_r;
  logic               degen_o_r;

  assign adv        = ~vld_r[LAT-1] | out_tready;
  assign in_tready  = adv;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {1'b0, gamma_r, beta_r, alpha_r};
  assign out_tuser  = degen_o_r;

  assign vld_nxt = {vld_r[LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= '0;
    end else begin
      if (adv) begin
        vld_r <= vld_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  // stage 1: z = upper - centre, s = lateral - centre
  always_ff @(posedge clk) begin
    if (adv) begin
      z0_r <= DIFF_W'($signed(in_tdata[79:60]))   - DIFF_W'($signed(in_tdata[19:0]));
      z1_r <= DIFF_W'($signed(in_tdata[99:80]))   - DIFF_W'($signed(in_tdata[39:20]));
      z2_r <= DIFF_W'($signed(in_tdata[119:100])) - DIFF_W'($signed(in_tdata[59:40]));
      s0_r <= DIFF_W'($signed(in_tdata[139:120])) - DIFF_W'($signed(in_tdata[19:0]));
      s1_r <= DIFF_W'($signed(in_tdata[159:140])) - DIFF_W'($signed(in_tdata[39:20]));
      s2_r <= DIFF_W'($signed(in_tdata[179:160])) - DIFF_W'($signed(in_tdata[59:40]));
    end
  end

  // stage 2: x = s cross z, squared projection, z_z squared
  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r   <= 43'(s1_r) * 43'(z2_r) - 43'(s2_r) * 43'(z1_r);
      x1_r   <= 43'(s2_r) * 43'(z0_r) - 43'(s0_r) * 43'(z2_r);
      x2_r   <= 43'(s0_r) * 43'(z1_r) - 43'(s1_r) * 43'(z0_r);
      p_r    <= 42'(42'(z0_r) * 42'(z0_r) + 42'(z1_r) * 42'(z1_r));
      z2sq_r <= 41'(42'(z2_r) * 42'(z2_r));
      z0b_r  <= z0_r;
      z1b_r  <= z1_r;
      z2b_r  <= z2_r;
    end
  end

  // stage 3: branch decision, |z|^2, alpha x operand, gamma operands
  assign degen_nxt = {1'b0, p_r} <= thr_r;
  assign b_nxt     = 64'(x0_r) * 64'(z1b_r) - 64'(x1_r) * 64'(z0b_r);
  assign gy_nxt    = degen_nxt ? x1_r : -43'(z0b_r);
  assign gx_nxt    = degen_nxt ? x0_r : 43'(z1b_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      degen_r <= degen_nxt;
      nz_r    <= 43'(p_r) + 43'(z2sq_r);
      x2neg_r <= x2_r[42];
      mx2_r   <= x2_r[42] ? 42'(-x2_r) : 42'(x2_r);
      bneg_r  <= b_nxt[63];
      mb_r    <= b_nxt[63] ? BM_W'(-b_nxt) : BM_W'(b_nxt);
      gyneg_r <= gy_nxt[42];
      gym_r   <= gy_nxt[42] ? GM_W'(-gy_nxt) : GM_W'(gy_nxt);
      gxneg_r <= gx_nxt[42];
      gxm_r   <= gx_nxt[42] ? GM_W'(-gx_nxt) : GM_W'(gx_nxt);
      z2pos_r <= z2b_r > 0;
      z2neg_r <= z2b_r[DIFF_W-1];
      z2m_r   <= z2b_r[DIFF_W-1] ? DIFF_W'(-z2b_r) : DIFF_W'(z2b_r);
    end
  end

  // stages 4 and 5: |x2| * |z|^2 split in two partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      pp_lo_r  <= 64'(mx2_r) * 64'(nz_r[21:0]);
      pp_hi_r  <= 63'(mx2_r) * 63'(nz_r[42:22]);
      x2neg4_r <= x2neg_r;
      bneg4_r  <= bneg_r;
      mb4_r    <= mb_r;
      ya_r     <= YA_W'(pp_lo_r) + (YA_W'(pp_hi_r) << 22);
      x2neg5_r <= x2neg4_r;
      bneg5_r  <= bneg4_r;
      mb5_r    <= mb4_r;
    end
  end

  // square root of p * 2^20, one result bit per cell
  assign sq_rem[0]  = {2'b00, p_r, 20'd0};
  assign sq_root[0] = '0;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sq
    eafp_sqrt_cell #(.BIT_POS(2 * (SQRT_CELLS - 1 - i))) u_cell (
      .clk(clk), .adv(adv),
      .rem_i(sq_rem[i]), .root_i(sq_root[i]),
      .rem_o(sq_rem[i+1]), .root_o(sq_root[i+1])
    );
  end

  // line the other operands up with the root
  eafp_delay #(.W(YA_W + BM_W + 2), .DEPTH(A_DLY)) u_adly (
    .clk(clk), .adv(adv), .d_i({x2neg5_r, bneg5_r, ya_r, mb5_r}), .d_o(a_d)
  );
  eafp_delay #(.W(2 * GM_W + 2), .DEPTH(G_DLY)) u_gdly (
    .clk(clk), .adv(adv), .d_i({gyneg_r, gxneg_r, gym_r, gxm_r}), .d_o(g_d)
  );
  eafp_delay #(.W(DIFF_W + 1), .DEPTH(G_DLY)) u_bdly (
    .clk(clk), .adv(adv), .d_i({z2neg_r, z2m_r}), .d_o(bx_d)
  );
  eafp_delay #(.W(2), .DEPTH(F_DLY)) u_fdly (
    .clk(clk), .adv(adv), .d_i({degen_r, z2pos_r}), .d_o(f_d)
  );

  eafp_atan_pipe #(.IN_W(YA_W), .STAGES(CORDIC_STAGES)) u_alpha (
    .clk(clk), .adv(adv),
    .yneg(a_d[YA_W+BM_W+1]), .xneg(a_d[YA_W+BM_W]),
    .ym(a_d[YA_W+BM_W-1:BM_W]), .xm(YA_W'(a_d[BM_W-1:0])),
    .angle_r(a_ang)
  );

  eafp_atan_pipe #(.IN_W(BT_W), .STAGES(CORDIC_STAGES)) u_beta (
    .clk(clk), .adv(adv),
    .yneg(1'b0), .xneg(bx_d[DIFF_W]),
    .ym(sq_root[SQRT_CELLS][BT_W-1:0]), .xm({bx_d[DIFF_W-1:0], 10'd0}),
    .angle_r(b_ang)
  );

  eafp_atan_pipe #(.IN_W(GM_W), .STAGES(CORDIC_STAGES)) u_gamma (
    .clk(clk), .adv(adv),
    .yneg(g_d[2*GM_W+1]), .xneg(g_d[2*GM_W]),
    .ym(g_d[2*GM_W-1:GM_W]), .xm(g_d[GM_W-1:0]),
    .angle_r(g_ang)
  );

  // output register: pick the branch, negate gamma
  always_ff @(posedge clk) begin
    if (adv) begin
      degen_o_r <= f_d[1];
      gamma_r   <= ANGLE_W'(-g_ang);
      if (f_d[1]) begin
        alpha_r <= '0;
        beta_r  <= f_d[0] ? '0 : BETA_W'(PI_Q13);
      end else begin
        alpha_r <= a_ang;
        beta_r  <= b_ang[ANGLE_W-1] ? '0 : BETA_W'(b_ang);
      end
    end
  end

  a_degen_alpha : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[15:0] == '0)
    else $error("degenerate result with nonzero alpha");

  a_degen_beta : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[30:16] == '0 || out_tdata[30:16] == BETA_W'(PI_Q13)))
    else $error("degenerate beta is neither 0 nor pi");

  a_beta_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[30:16] <= BETA_W'(PI_Q13))
    else $error("beta beyond pi");

  a_gamma_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[46:31]) <= PI_Q13 &&
                    $signed(out_tdata[46:31]) >= -PI_Q13))
    else $error("gamma beyond +-pi");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

endmodule

@@ dv/tb_euler_angles_from_three_points.sv @@
`timescale 1ns / 100ps

module tb_euler_angles_from_three_points;
  import eafp_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    logic signed [ANGLE_W-1:0] alpha;
    logic [BETA_W-1:0]         beta;
    logic signed [ANGLE_W-1:0] gamma;
    logic                      degen;
  } angles_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [183:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [THR_W-1:0] cfg_data = '0;

  // Threshold copy held by the predictor; follows every accepted cfg write
  logic [THR_W-1:0] thr_shadow = '0;
  angles_t pending_angles[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold_cycles = 0;

  euler_angles_from_three_points dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("[euler_angles_from_three_points] ERROR");
    $finish;
  end

  // Vectoring CORDIC on sign/magnitude operands, result in Q3.13
  function automatic logic signed [ANGLE_W-1:0] cordic_atan2(bit yneg, logic [127:0] ym,
                                                             bit xneg, logic [127:0] xm);
    longint x, y, z, t, q, dx, dy;
    int i, n;
    if (ym == 0 && xm == 0) return '0;
    for (i = 0; i < 130 && ((ym | xm) >> 40) != 0; i++) begin
      ym = ym >> 1;
      xm = xm >> 1;
    end
    for (i = 0; i < 40 && ((ym | xm) >> 38) == 0; i++) begin
      ym = ym << 1;
      xm = xm << 1;
    end
    y = yneg ? -longint'(ym[63:0]) : longint'(ym[63:0]);
    x = xneg ? -longint'(xm[63:0]) : longint'(xm[63:0]);
    z = 0;
    // Quarter-turn pre-rotation for the left half-plane; y of zero counts as positive
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q24;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q24;
      end
    end
    n = (CORDIC_STAGES_DEF > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STAGES_DEF;
    for (i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_Q24[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_Q24[i]);
      end
    end
    q = ((z + (64'sd1 <<< 30) + 1024) >>> 11) - (64'sd1 <<< 19);
    if (q > PI_Q13) q = PI_Q13;
    if (q < -PI_Q13) q = -PI_Q13;
    return q[ANGLE_W-1:0];
  endfunction

  function automatic logic signed [ANGLE_W-1:0] atan2_signed(longint y, longint x);
    logic [127:0] ym, xm;
    ym = (y < 0) ? 128'(-y) : 128'(y);
    xm = (x < 0) ? 128'(-x) : 128'(x);
    return cordic_atan2(y < 0, ym, x < 0, xm);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // pt: centre xyz, upper xyz, lateral xyz
  function automatic angles_t frame_angles(coord_t pt[9]);
    angles_t a;
    longint z0, z1, z2, s0, s1, s2, x0, x1, x2, p, nz, b, bt;
    logic [127:0] prod;
    z0 = longint'(pt[3]) - longint'(pt[0]);
    z1 = longint'(pt[4]) - longint'(pt[1]);
    z2 = longint'(pt[5]) - longint'(pt[2]);
    s0 = longint'(pt[6]) - longint'(pt[0]);
    s1 = longint'(pt[7]) - longint'(pt[1]);
    s2 = longint'(pt[8]) - longint'(pt[2]);
    x0 = s1 * z2 - s2 * z1;
    x1 = s2 * z0 - s0 * z2;
    x2 = s0 * z1 - s1 * z0;
    p = z0 * z0 + z1 * z1;
    if (p > longint'(thr_shadow)) begin
      nz = p + z2 * z2;
      b = x0 * z1 - x1 * z0;
      prod = 128'((x2 < 0) ? -x2 : x2) * 128'(nz);
      a.alpha = cordic_atan2(x2 < 0, prod, b < 0, 128'((b < 0) ? -b : b));
      bt = atan2_signed(longint'(int_sqrt(64'(p) << 20)), z2 * 1024);
      if (bt < 0) bt = 0;
      a.beta = bt[BETA_W-1:0];
      a.gamma = -atan2_signed(-z0, z1);
      a.degen = 1'b0;
    end else begin
      a.alpha = '0;
      a.beta = (z2 > 0) ? '0 : BETA_W'(PI_Q13);
      a.gamma = -atan2_signed(x1, x0);
      a.degen = 1'b1;
    end
    return a;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
  endtask

  // Result checker: compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    angles_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = pending_angles.pop_front();
        if ($signed(out_tdata[15:0]) !== w.alpha)
          report_mismatch("alpha", $signed(out_tdata[15:0]), w.alpha);
        if (out_tdata[30:16] !== w.beta)
          report_mismatch("beta", out_tdata[30:16], w.beta);
        if ($signed(out_tdata[46:31]) !== w.gamma)
          report_mismatch("gamma", $signed(out_tdata[46:31]), w.gamma);
        if (out_tdata[47] !== 1'b0)
          report_mismatch("pad bit", out_tdata[47], 0);
        if (out_tuser !== w.degen)
          report_mismatch("degenerate", out_tuser, w.degen);
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off when requested
  initial begin
    forever begin
      @(posedge clk);
      if (recv_hold_cycles > 0) begin
        out_tready <= 1'b0;
        recv_hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_points(coord_t pt[9]);
    logic [183:0] d;
    d = '0;
    for (int k = 0; k < 9; k++) d[k*COORD_W +: COORD_W] = pt[k];
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    pending_angles.push_back(frame_angles(pt));
  endtask

  // Drop valid and wait for every outstanding result, then let the pipe empty
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_shadow = v;
  endtask

  function automatic coord_t near_coord(coord_t c, int span);
    return c + coord_t'($urandom_range(2 * span) - span);
  endfunction

  // Mix of full-range points, tight clusters and near-axial up vectors
  task automatic send_random_points();
    coord_t pt[9];
    int span;
    case ($urandom_range(3))
      0: begin
        for (int k = 0; k < 9; k++) pt[k] = coord_t'($urandom);
      end
      1, 2: begin
        span = 1 << $urandom_range(1, 17);
        for (int k = 0; k < 3; k++) pt[k] = coord_t'($urandom);
        for (int k = 3; k < 9; k++) pt[k] = near_coord(pt[k % 3], span);
      end
      default: begin
        for (int k = 0; k < 3; k++) pt[k] = coord_t'($urandom);
        pt[3] = near_coord(pt[0], $urandom_range(0, 3) * 64);
        pt[4] = near_coord(pt[1], $urandom_range(0, 3) * 64);
        pt[5] = coord_t'($urandom);
        for (int k = 6; k < 9; k++) pt[k] = near_coord(pt[k - 6], 1 << $urandom_range(1, 16));
      end
    endcase
    send_points(pt);
  endtask

  task automatic test_directed();
    coord_t mx, mn;
    coord_t pt[9];
    mx = coord_t'(20'h7FFFF);
    mn = coord_t'(20'h80000);
    // coincident points: every vector zero
    pt = '{default: '0};
    send_points(pt);
    // up vector straight along +z and along -z: degenerate, beta 0 and pi
    pt = '{0, 0, 0, 0, 0, 1024, 1024, 0, 0};
    send_points(pt);
    pt = '{0, 0, 0, 0, 0, -1024, 0, 1024, 0};
    send_points(pt);
    // up vector zero but lateral offset
    pt = '{5, 5, 5, 5, 5, 5, 900, -300, 7};
    send_points(pt);
    // axis extremes: full-range differences, then all points at one extreme
    pt = '{mn, mn, mn, mx, mx, mx, mx, mn, mn};
    send_points(pt);
    pt = '{mx, mx, mx, mn, mn, mn, mn, mx, mn};
    send_points(pt);
    pt = '{mn, mx, mn, mx, mn, mx, mn, mn, mx};
    send_points(pt);
    pt = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};
    send_points(pt);
    pt = '{mn, mn, mn, mn, mn, mn, mn, mn, mn};
    send_points(pt);
    // z along the x and y axes (negative x for the quarter turn), then general cases
    pt = '{0, 0, 0, 1024, 0, 0, 0, 1024, 0};
    send_points(pt);
    pt = '{0, 0, 0, -1024, 0, 0, 0, 0, 1024};
    send_points(pt);
    pt = '{0, 0, 0, 0, 1024, 0, 0, 0, -1024};
    send_points(pt);
    pt = '{0, 0, 0, 0, -1024, 0, 1024, 0, 0};
    send_points(pt);
    pt = '{0, 0, 0, -3, -5, 2, -7, 4, 1};
    send_points(pt);
    pt = '{100, -200, 300, 101, -200, 900, -500, 60, 300};
    send_points(pt);
    pt = '{0, 0, 0, 1, 1, -1, 1, -1, 0};
    send_points(pt);
    // lateral point on the up axis: x axis collapses to zero
    pt = '{0, 0, 0, 3000, 4000, 500, 6000, 8000, 1000};
    send_points(pt);
    drain_pipe();
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_random_points();
    drain_pipe();
  endtask

  // Hold the receiver off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_cycles = 300;
    repeat (150) send_random_points();
    drain_pipe();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    write_threshold('0);
    test_random(250, 34, 58);
    write_threshold({THR_W{1'b1}});
    test_directed();
    test_random(100, 58, 34);
    write_threshold(THR_W'($urandom_range(1 << 20, 1 << 30)));
    test_random(200, 58, 34);
    write_threshold(THR_W'(1 << 24));
    test_random(150, 0, 0);
    test_backpressure();

    if (errors == 0) begin
      $display("[euler_angles_from_three_points] OK");
    end else begin
      $display("[euler_angles_from_three_points] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/eafp_pkg.sv
design/eafp_delay.sv
design/eafp_sqrt_cell.sv
design/eafp_norm_cell.sv
design/eafp_cordic_cell.sv
design/eafp_atan_pipe.sv
design/euler_angles_from_three_points.sv
dv/tb_euler_angles_from_three_points.sv
